// File: rtl/core/tfun_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants for the triangle unit-normal pipeline.
// No dependencies.
package tfun_pkg;

    // x, y, z
    localparam int NUM_AXES = 3;

    typedef logic [1:0] t_axis_idx;

endpackage

// File: rtl/core/triangle_face_unit_normal_top.sv
`timescale 1ns / 1ps
// Triangle face unit normal: edges, cross product, length and normalize, fully pipelined.
// Depends on tfun_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------------
//  request  | in        | i_valid / o_stall    | i_v{1,2,3}_{x,y,z}, Q7.8 signed
//  result   | out       | o_valid / i_stall    | o_normal_{x,y,z} Q1.14, o_degenerate
//
// One request enters per cycle while o_stall is low; the stages in order are the
// edges, products, cross, partial squares, squares, length sum, then one
// restoring square-root-division step per result bit, then the output register.
// The normalize chain sets the depth: one bit per stage, each a ~100-bit add and compare.
// The whole pipe moves as one; it holds only while a result waits under i_stall.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
module triangle_face_unit_normal_top #(
    parameter int COORD_WIDTH   = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_v1_x,
    input  logic signed [COORD_WIDTH-1:0] i_v1_y,
    input  logic signed [COORD_WIDTH-1:0] i_v1_z,
    input  logic signed [COORD_WIDTH-1:0] i_v2_x,
    input  logic signed [COORD_WIDTH-1:0] i_v2_y,
    input  logic signed [COORD_WIDTH-1:0] i_v2_z,
    input  logic signed [COORD_WIDTH-1:0] i_v3_x,
    input  logic signed [COORD_WIDTH-1:0] i_v3_y,
    input  logic signed [COORD_WIDTH-1:0] i_v3_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [OUT_FRAC_BITS+1:0] o_normal_x,
    output logic signed [OUT_FRAC_BITS+1:0] o_normal_y,
    output logic signed [OUT_FRAC_BITS+1:0] o_normal_z,
    output logic                         o_degenerate
);

    localparam int F   = OUT_FRAC_BITS;
    localparam int NA  = tfun_pkg::NUM_AXES;
    localparam int EW  = COORD_WIDTH + 1;     // edge
    localparam int PW  = 2 * EW;              // edge product
    localparam int CXW = PW + 1;              // signed cross component
    localparam int MW  = PW;                  // |cross|
    localparam int H   = (MW + 1) / 2;        // low half for squaring
    localparam int HW  = MW - H;              // high half
    localparam int SQW = 2 * MW;              // cross squared
    localparam int SW  = SQW + 2;             // sum of three squares
    localparam int RW  = SQW + 2 * F;         // remainder
    localparam int AW  = SW + F + 1;          // S * q
    localparam int XW  = SW + 2 * F + 3;      // trial compare width
    localparam int OW  = F + 2;
    localparam int NIT = F + 1;               // root steps

    // Whole pipe advances unless the finished result is held.
    logic w_adv;
    assign o_stall = o_valid && i_stall;
    assign w_adv   = !o_stall;

    // ---- stage 1: edge vectors
    logic                 r_v1;
    logic signed [EW-1:0] r_e1 [NA];
    logic signed [EW-1:0] r_e2 [NA];
    logic signed [COORD_WIDTH-1:0] w_a [NA];
    logic signed [COORD_WIDTH-1:0] w_b [NA];
    logic signed [COORD_WIDTH-1:0] w_c [NA];

    assign w_a[0] = i_v1_x; assign w_a[1] = i_v1_y; assign w_a[2] = i_v1_z;
    assign w_b[0] = i_v2_x; assign w_b[1] = i_v2_y; assign w_b[2] = i_v2_z;
    assign w_c[0] = i_v3_x; assign w_c[1] = i_v3_y; assign w_c[2] = i_v3_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NA; i++) begin
                r_e1[i] <= EW'(w_a[i]) - EW'(w_b[i]);
                r_e2[i] <= EW'(w_b[i]) - EW'(w_c[i]);
            end
        end
    end

    // ---- stage 2: edge products, a plus term p and a minus term m per axis
    logic                 r_v2;
    logic signed [PW-1:0] r_p [NA];
    logic signed [PW-1:0] r_m [NA];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p[0] <= PW'(r_e1[1] * r_e2[2]);
            r_m[0] <= PW'(r_e2[1] * r_e1[2]);
            r_p[1] <= PW'(r_e1[2] * r_e2[0]);
            r_m[1] <= PW'(r_e2[2] * r_e1[0]);
            r_p[2] <= PW'(r_e1[0] * r_e2[1]);
            r_m[2] <= PW'(r_e2[0] * r_e1[1]);
        end
    end

    // ---- stage 3: cross product as sign and magnitude
    logic                  r_v3;
    logic [MW-1:0]         r_mag3 [NA];
    logic [NA-1:0]         r_neg3;
    logic signed [CXW-1:0] w_cx [NA];

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_cx[i] = CXW'(r_p[i]) - CXW'(r_m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NA; i++) begin
                r_neg3[i] <= w_cx[i][CXW-1];
                r_mag3[i] <= w_cx[i][CXW-1] ? MW'(-w_cx[i]) : MW'(w_cx[i]);
            end
        end
    end

    // ---- stage 4: squares split in halves
    logic              r_v4;
    logic [2*HW-1:0]   r_hh [NA];
    logic [HW+H-1:0]   r_hl [NA];
    logic [2*H-1:0]    r_ll [NA];
    logic [NA-1:0]     r_neg4;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg4 <= r_neg3;
            for (int i = 0; i < NA; i++) begin
                r_hh[i] <= r_mag3[i][MW-1:H] * r_mag3[i][MW-1:H];
                r_hl[i] <= r_mag3[i][MW-1:H] * r_mag3[i][H-1:0];
                r_ll[i] <= r_mag3[i][H-1:0] * r_mag3[i][H-1:0];
            end
        end
    end

    // ---- stage 5: cross squared per axis
    logic           r_v5;
    logic [SQW-1:0] r_sq [NA];
    logic [NA-1:0]  r_neg5;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg5 <= r_neg4;
            for (int i = 0; i < NA; i++) begin
                r_sq[i] <= (SQW'(r_hh[i]) << (2 * H)) + (SQW'(r_hl[i]) << (H + 1))
                         + SQW'(r_ll[i]);
            end
        end
    end

    // ---- stage 6 and root steps: index k holds the state before step k
    logic             r_vit  [NIT+1];
    logic [SW-1:0]    r_s    [NIT+1];
    logic             r_deg  [NIT+1];
    logic [NA-1:0]    r_negi [NIT+1];
    logic [RW-1:0]    r_rem  [NIT+1][NA];
    logic [AW-1:0]    r_acc  [NIT+1][NA];
    logic [F:0]       r_q    [NIT+1][NA];
    logic [SW-1:0]    w_s;

    assign w_s = SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s[0]    <= w_s;
            r_deg[0]  <= (w_s == '0);
            r_negi[0] <= r_neg5;
            for (int i = 0; i < NA; i++) begin
                r_rem[0][i] <= RW'(r_sq[i]) << (2 * F);
                r_acc[0][i] <= '0;
                r_q[0][i]   <= '0;
            end
        end
    end

    // Step for bit b: (q + 2^b)^2 S - q^2 S = (S q) 2^(b+1) + S 2^(2b).
    for (genvar k = 0; k < NIT; k++) begin : g_root
        localparam int B = F - k;
        for (genvar j = 0; j < NA; j++) begin : g_axis
            logic [XW-1:0] w_d;
            logic          w_take;
            assign w_d    = (XW'(r_acc[k][j]) << (B + 1)) + (XW'(r_s[k]) << (2 * B));
            assign w_take = XW'(r_rem[k][j]) >= w_d;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    if (w_take) begin
                        r_rem[k+1][j] <= r_rem[k][j] - RW'(w_d);
                        r_acc[k+1][j] <= r_acc[k][j] + (AW'(r_s[k]) << B);
                        r_q[k+1][j]   <= r_q[k][j] | ((F+1)'(1) << B);
                    end else begin
                        r_rem[k+1][j] <= r_rem[k][j];
                        r_acc[k+1][j] <= r_acc[k][j];
                        r_q[k+1][j]   <= r_q[k][j];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s[k+1]    <= r_s[k];
                r_deg[k+1]  <= r_deg[k];
                r_negi[k+1] <= r_negi[k];
            end
        end
    end

    // ---- output register: sign applied, zero vector when degenerate
    logic                 r_out_vld;
    logic signed [OW-1:0] r_n [NA];
    logic                 r_deg_out;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_deg_out <= r_deg[NIT];
            for (int i = 0; i < NA; i++) begin
                if (r_deg[NIT]) begin
                    r_n[i] <= '0;
                end else if (r_negi[NIT][i]) begin
                    r_n[i] <= -OW'(r_q[NIT][i]);
                end else begin
                    r_n[i] <= OW'(r_q[NIT][i]);
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NIT; k++) begin
                r_vit[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_vit[0]  <= r_v5;
            for (int k = 0; k < NIT; k++) begin
                r_vit[k+1] <= r_vit[k];
            end
            r_out_vld <= r_vit[NIT];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_normal_x   = r_n[0];
    assign o_normal_y   = r_n[1];
    assign o_normal_z   = r_n[2];
    assign o_degenerate = r_deg_out;

    localparam logic signed [OW-1:0] ONE_Q = OW'(1) << F;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> (o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0))
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x <= ONE_Q && o_normal_x >= -ONE_Q
                  && o_normal_y <= ONE_Q && o_normal_y >= -ONE_Q
                  && o_normal_z <= ONE_Q && o_normal_z >= -ONE_Q))
        else $error("normal component beyond unit range");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v1)
        else $error("accepted request lost at pipe entry");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_vit[NIT] == $past(r_vit[NIT]))
        else $error("pipe moved while output stalled");

endmodule
